// ===== rtl/core/smf_pkg.sv =====
// Shared types and constants for the marked sample FIFO with timestamps.
// Depends on nothing; used by the top level by scoped names.
`default_nettype none

package smf_pkg;

	localparam int DEPTH      = 1024;
	localparam int TIME_DEPTH = 64;
	localparam int SAMPLE_W   = 32;
	localparam int MAX_POP    = 64;

	localparam int PTR_W  = $clog2(DEPTH);
	localparam int TPTR_W = (TIME_DEPTH > 1) ? $clog2(TIME_DEPTH) : 1;
	localparam int TCNT_W = $clog2(TIME_DEPTH + 1);

	// Fixed field widths of the item formats
	localparam int WORD_W = 32;
	localparam int LEN_W  = 10;
	localparam int TIME_W = 64;
	localparam int CNT_W  = 7;
	localparam int OFF_W  = 16;
	localparam int STAT_W = 2;

	localparam int MAX_W0 = (PTR_W > CNT_W) ? PTR_W : CNT_W;
	localparam int MAX_W1 = (MAX_W0 > LEN_W) ? MAX_W0 : LEN_W;
	localparam int CMP_W  = MAX_W1 + 1;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [STAT_W-1:0] STAT_PUSH_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_PUSH_DROP = 2'd1;
	localparam logic [STAT_W-1:0] STAT_POPPED    = 2'd2;
	localparam logic [STAT_W-1:0] STAT_POP_REFUSED = 2'd3;

	typedef struct packed {
		logic              operation;
		logic [WORD_W-1:0] sample_word;
		logic              first_of_vector;
		logic [LEN_W-1:0]  vector_length;
		logic [TIME_W-1:0] time_stamp;
		logic [CNT_W-1:0]  pop_count;
	} req_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [WORD_W-1:0] sample_word_out;
		logic [TIME_W-1:0] vector_time;
		logic [OFF_W-1:0]  offset;
		logic              last;
	} rsp_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/marked_sample_fifo_with_timestamps.sv =====
// Top level of the marked sample FIFO: sample ring, timestamp ring and pop sequencer.
// Depends on smf_pkg for item types, sizes and status codes.
`default_nettype none

// Sample ring buffer that stores whole vectors with a start mark per sample and
// a queue of vector start times. A push gives one result; a new item is
// taken every cycle while the result register drains. A pop of N samples gives
// N results at one per cycle while the result side takes them: the request first
// enters the pop sequencer, then each sample is read through the registered read
// port of the sample memory; the next item is taken once the last sample is
// loaded into the result register. A refused pop gives a single result.
// Samples and marks share one 1024-entry memory, start times a 64-entry memory.
// Backpressure on the result side freezes the whole pop sequence in place.
module marked_sample_fifo_with_timestamps (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire smf_pkg::req_item_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output smf_pkg::rsp_item_t      rsp
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_POP  = 1'b1;

	logic state_q, state_d;

	logic [smf_pkg::PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d;
	logic [smf_pkg::TPTR_W-1:0] twp_q, twp_d, trp_q, trp_d;
	logic [smf_pkg::TCNT_W-1:0] tcnt_q, tcnt_d;
	logic                       drop_q, drop_d;
	logic [smf_pkg::LEN_W-1:0]  vrem_q, vrem_d;
	logic [smf_pkg::TIME_W-1:0] cur_time_q, cur_time_d;
	logic [smf_pkg::OFF_W-1:0]  off_q, off_d;
	logic [smf_pkg::CNT_W-1:0]  left_q, left_d;

	logic s1_valid_q, s1_valid_d;
	logic s1_last_q, s1_last_d;
	logic [smf_pkg::SAMPLE_W-1:0] s1_sample_q;
	logic                         s1_mark_q;
	logic [smf_pkg::TIME_W-1:0]   time_rd_q;

	logic               rsp_valid_q;
	smf_pkg::rsp_item_t rsp_q, rsp_d;
	logic               rsp_load;

	// Sample memory holds {mark, sample}
	logic [smf_pkg::SAMPLE_W:0]   smem [smf_pkg::DEPTH];
	logic [smf_pkg::TIME_W-1:0]   tmem [smf_pkg::TIME_DEPTH];
	logic                         smem_we, smem_re, smem_wmark;
	logic                         tmem_we;

	logic                      adv, accept, pop_refuse, push_refuse;
	logic [smf_pkg::CMP_W-1:0] stored, free_space;
	logic [smf_pkg::PTR_W-1:0] wp_inc, rp_inc;
	logic [smf_pkg::TPTR_W-1:0] twp_inc, trp_inc;

	assign adv       = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE) && adv;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign wp_inc  = (wp_q == smf_pkg::PTR_W'(smf_pkg::DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_inc  = (rp_q == smf_pkg::PTR_W'(smf_pkg::DEPTH - 1)) ? '0 : rp_q + 1'b1;
	assign twp_inc = (twp_q == smf_pkg::TPTR_W'(smf_pkg::TIME_DEPTH - 1)) ? '0 : twp_q + 1'b1;
	assign trp_inc = (trp_q == smf_pkg::TPTR_W'(smf_pkg::TIME_DEPTH - 1)) ? '0 : trp_q + 1'b1;

	always_comb begin
		if (wp_q >= rp_q) begin
			stored = smf_pkg::CMP_W'(wp_q) - smf_pkg::CMP_W'(rp_q);
		end else begin
			stored = smf_pkg::CMP_W'(wp_q) + smf_pkg::CMP_W'(smf_pkg::DEPTH)
				- smf_pkg::CMP_W'(rp_q);
		end
		free_space = smf_pkg::CMP_W'(smf_pkg::DEPTH - 1) - stored;
	end

	assign push_refuse = (req.vector_length == '0)
		|| (free_space < smf_pkg::CMP_W'(req.vector_length))
		|| (tcnt_q >= smf_pkg::TCNT_W'(smf_pkg::TIME_DEPTH));
	assign pop_refuse = (req.pop_count == '0)
		|| (req.pop_count > smf_pkg::CNT_W'(smf_pkg::MAX_POP))
		|| (stored < smf_pkg::CMP_W'(req.pop_count));

	always_comb begin
		state_d    = state_q;
		wp_d       = wp_q;
		rp_d       = rp_q;
		twp_d      = twp_q;
		trp_d      = trp_q;
		tcnt_d     = tcnt_q;
		drop_d     = drop_q;
		vrem_d     = vrem_q;
		cur_time_d = cur_time_q;
		off_d      = off_q;
		left_d     = left_q;
		s1_valid_d = s1_valid_q;
		s1_last_d  = s1_last_q;
		smem_we    = 1'b0;
		smem_wmark = 1'b0;
		smem_re    = 1'b0;
		tmem_we    = 1'b0;
		rsp_load   = 1'b0;
		rsp_d      = '0;
		rsp_d.last = 1'b1;

		if (accept) begin
			rsp_load = 1'b1;
			if (req.operation == smf_pkg::OP_PUSH) begin
				rsp_d.status = smf_pkg::STAT_PUSH_DROP;
				if (req.first_of_vector) begin
					vrem_d = (req.vector_length != '0) ? req.vector_length - 1'b1 : '0;
					if (push_refuse) begin
						drop_d = 1'b1;
					end else begin
						drop_d       = 1'b0;
						tmem_we      = 1'b1;
						twp_d        = twp_inc;
						tcnt_d       = tcnt_q + 1'b1;
						smem_we      = 1'b1;
						smem_wmark   = 1'b1;
						wp_d         = wp_inc;
						rsp_d.status = smf_pkg::STAT_PUSH_OK;
					end
				end else if (vrem_q != '0) begin
					vrem_d = vrem_q - 1'b1;
					if (!drop_q) begin
						smem_we      = 1'b1;
						wp_d         = wp_inc;
						rsp_d.status = smf_pkg::STAT_PUSH_OK;
					end
				end
			end else if (pop_refuse) begin
				rsp_d.status = smf_pkg::STAT_POP_REFUSED;
			end else begin
				rsp_load = 1'b0;
				state_d  = ST_POP;
				left_d   = req.pop_count;
			end
		end

		if (state_q == ST_POP && adv) begin
			// Issue the next read while the previous sample is finished
			s1_valid_d = (left_q != '0);
			if (left_q != '0) begin
				smem_re   = 1'b1;
				rp_d      = rp_inc;
				left_d    = left_q - 1'b1;
				s1_last_d = (left_q == smf_pkg::CNT_W'(1));
			end
			if (s1_valid_q) begin
				if (s1_mark_q) begin
					if (tcnt_q != '0) begin
						cur_time_d = time_rd_q;
						trp_d      = trp_inc;
						tcnt_d     = tcnt_q - 1'b1;
					end
					off_d = '0;
				end else if (off_q != '1) begin
					off_d = off_q + 1'b1;
				end
				rsp_load              = 1'b1;
				rsp_d.status          = smf_pkg::STAT_POPPED;
				rsp_d.sample_word_out = smf_pkg::WORD_W'(s1_sample_q);
				rsp_d.vector_time     = cur_time_d;
				rsp_d.offset          = off_d;
				rsp_d.last            = s1_last_q;
				if (s1_last_q) begin
					state_d = ST_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			rp_q        <= '0;
			twp_q       <= '0;
			trp_q       <= '0;
			tcnt_q      <= '0;
			drop_q      <= 1'b0;
			vrem_q      <= '0;
			cur_time_q  <= '0;
			off_q       <= '0;
			left_q      <= '0;
			s1_valid_q  <= 1'b0;
			s1_last_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			wp_q       <= wp_d;
			rp_q       <= rp_d;
			twp_q      <= twp_d;
			trp_q      <= trp_d;
			tcnt_q     <= tcnt_d;
			drop_q     <= drop_d;
			vrem_q     <= vrem_d;
			cur_time_q <= cur_time_d;
			off_q      <= off_d;
			left_q     <= left_d;
			s1_valid_q <= s1_valid_d;
			s1_last_q  <= s1_last_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	// Sample memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (smem_we) begin
			smem[wp_q] <= {smem_wmark, req.sample_word[smf_pkg::SAMPLE_W-1:0]};
		end
		if (smem_re) begin
			{s1_mark_q, s1_sample_q} <= smem[rp_q];
		end
	end

	// Timestamp memory: read the head as it will be next cycle, so a mark finds it ready
	always_ff @(posedge clk) begin
		if (tmem_we) begin
			tmem[twp_q] <= req.time_stamp;
		end
		time_rd_q <= tmem[trp_d];
	end

`ifndef SYNTHESIS
	a_tcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tcnt_q <= smf_pkg::TCNT_W'(smf_pkg::TIME_DEPTH))
		else $error("timestamp count above capacity");

	a_mark_has_time: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP && adv && s1_valid_q && s1_mark_q) |-> (tcnt_q != '0))
		else $error("marked sample popped with no queued timestamp");

	a_s1_only_in_pop: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> (state_q == ST_POP))
		else $error("sample stage valid outside a pop");

	a_last_ends_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP && adv && s1_valid_q && s1_last_q)
		|=> (state_q == ST_IDLE && !s1_valid_q && left_q == '0))
		else $error("pop sequence did not close after its last sample");
`endif

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking bench for the marked sample FIFO with vector timestamps.
// Depends on smf_pkg for the item structs, sizes, operation and status codes.
// Predicts every result in step with each accepted item and checks in order.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	smf_pkg::req_item_t req;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	smf_pkg::rsp_item_t rsp;

	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;
	int mismatches;

	// Shadow copy of the FIFO state, advanced at each request transfer
	logic [smf_pkg::WORD_W-1:0] ring_word [smf_pkg::DEPTH];
	logic                       ring_mark [smf_pkg::DEPTH];
	logic [smf_pkg::PTR_W-1:0]  wr_ptr;
	logic [smf_pkg::PTR_W-1:0]  rd_ptr;
	logic [smf_pkg::TIME_W-1:0] stamp_ring [smf_pkg::TIME_DEPTH];
	logic [smf_pkg::TPTR_W-1:0] stamp_wr;
	logic [smf_pkg::TPTR_W-1:0] stamp_rd;
	int                         stamp_count;
	bit                         discarding;
	int                         samples_due;
	logic [smf_pkg::TIME_W-1:0] vector_start;
	logic [smf_pkg::OFF_W-1:0]  since_mark;

	smf_pkg::rsp_item_t awaited_results [$];

	marked_sample_fifo_with_timestamps dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	function automatic int stored_count();
		logic [smf_pkg::PTR_W-1:0] gap;
		gap = wr_ptr - rd_ptr;
		return int'(gap);
	endfunction

	function automatic logic [smf_pkg::TIME_W-1:0] rand_stamp();
		return {$urandom, $urandom};
	endfunction

	function automatic smf_pkg::rsp_item_t make_result(logic [smf_pkg::STAT_W-1:0] status,
			logic [smf_pkg::WORD_W-1:0] word, logic [smf_pkg::TIME_W-1:0] start,
			logic [smf_pkg::OFF_W-1:0] off, logic last_flag);
		smf_pkg::rsp_item_t r;
		r.status          = status;
		r.sample_word_out = word;
		r.vector_time     = start;
		r.offset          = off;
		r.last            = last_flag;
		return r;
	endfunction

	// Append one predicted result at the tail of the queue
	function automatic void queue_result(smf_pkg::rsp_item_t r);
		awaited_results.insert(awaited_results.size(), r);
	endfunction

	function automatic smf_pkg::req_item_t push_item(logic [smf_pkg::WORD_W-1:0] word,
			logic opens, logic [smf_pkg::LEN_W-1:0] len,
			logic [smf_pkg::TIME_W-1:0] stamp);
		smf_pkg::req_item_t item;
		item.operation       = smf_pkg::OP_PUSH;
		item.sample_word     = word;
		item.first_of_vector = opens;
		item.vector_length   = len;
		item.time_stamp      = stamp;
		item.pop_count       = smf_pkg::CNT_W'($urandom);
		return item;
	endfunction

	// Later sample of a vector; length and stamp are ignored, so fill them at random
	function automatic smf_pkg::req_item_t follow_on(logic [smf_pkg::WORD_W-1:0] word);
		return push_item(word, 1'b0, smf_pkg::LEN_W'($urandom), rand_stamp());
	endfunction

	function automatic smf_pkg::req_item_t pop_item(logic [smf_pkg::CNT_W-1:0] cnt);
		smf_pkg::req_item_t item;
		item.operation       = smf_pkg::OP_POP;
		item.sample_word     = $urandom;
		item.first_of_vector = 1'($urandom_range(1));
		item.vector_length   = smf_pkg::LEN_W'($urandom);
		item.time_stamp      = rand_stamp();
		item.pop_count       = cnt;
		return item;
	endfunction

	function automatic void store_word(logic [smf_pkg::WORD_W-1:0] word, logic mark);
		ring_word[wr_ptr] = word;
		ring_mark[wr_ptr] = mark;
		wr_ptr++;
	endfunction

	// Advance the shadow state by one accepted item and queue the results it causes
	function automatic void predict_fifo_response(smf_pkg::req_item_t item);
		int cnt;
		int i;
		if (item.operation == smf_pkg::OP_PUSH) begin
			if (item.first_of_vector) begin
				samples_due = (item.vector_length != 0) ? int'(item.vector_length) - 1 : 0;
				if (item.vector_length == 0
						|| (smf_pkg::DEPTH - 1 - stored_count()) < int'(item.vector_length)
						|| stamp_count >= smf_pkg::TIME_DEPTH) begin
					discarding = 1'b1;
					queue_result(make_result(smf_pkg::STAT_PUSH_DROP, '0, '0, '0, 1'b1));
				end else begin
					discarding = 1'b0;
					stamp_ring[stamp_wr] = item.time_stamp;
					stamp_wr++;
					stamp_count++;
					store_word(item.sample_word, 1'b1);
					queue_result(make_result(smf_pkg::STAT_PUSH_OK, '0, '0, '0, 1'b1));
				end
			end else if (samples_due == 0) begin
				queue_result(make_result(smf_pkg::STAT_PUSH_DROP, '0, '0, '0, 1'b1));
			end else begin
				samples_due--;
				if (discarding) begin
					queue_result(make_result(smf_pkg::STAT_PUSH_DROP, '0, '0, '0, 1'b1));
				end else begin
					store_word(item.sample_word, 1'b0);
					queue_result(make_result(smf_pkg::STAT_PUSH_OK, '0, '0, '0, 1'b1));
				end
			end
		end else begin
			cnt = int'(item.pop_count);
			if (cnt == 0 || cnt > smf_pkg::MAX_POP || stored_count() < cnt) begin
				queue_result(make_result(smf_pkg::STAT_POP_REFUSED, '0, '0, '0, 1'b1));
			end else begin
				for (i = 0; i < cnt; i++) begin
					if (ring_mark[rd_ptr]) begin
						if (stamp_count > 0) begin
							vector_start = stamp_ring[stamp_rd];
							stamp_rd++;
							stamp_count--;
						end
						since_mark = '0;
					end else if (since_mark != '1) begin
						since_mark++;
					end
					queue_result(make_result(smf_pkg::STAT_POPPED, ring_word[rd_ptr],
						vector_start, since_mark, i == cnt - 1));
					rd_ptr++;
				end
			end
		end
	endfunction

	task automatic flag_mismatch(string what);
		mismatches++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// Check each result transfer against the oldest prediction; randomise ready
	always @(posedge clk) begin : check_results
		smf_pkg::rsp_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_results.size() == 0) begin
				flag_mismatch($sformatf("result with nothing pending, status %0d", rsp.status));
			end else begin
				want = awaited_results[0];
				awaited_results.delete(0);
				compare_field("status", 64'(rsp.status), 64'(want.status));
				compare_field("sample_word_out", 64'(rsp.sample_word_out),
					64'(want.sample_word_out));
				compare_field("vector_time", rsp.vector_time, want.vector_time);
				compare_field("offset", 64'(rsp.offset), 64'(want.offset));
				compare_field("last", 64'(rsp.last), 64'(want.last));
			end
		end
		rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Leaves valid high so that a following call can carry on without a gap
	task automatic send_item(smf_pkg::req_item_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predict_fifo_response(item);
		items_sent++;
	endtask

	// Hold the sender until every predicted result has been taken
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_results.size() != 0);
	endtask

	task automatic send_pop_within_stock();
		int stock;
		stock = stored_count();
		if (stock > smf_pkg::MAX_POP)
			stock = smf_pkg::MAX_POP;
		send_item(pop_item(smf_pkg::CNT_W'((stock == 0) ? 1 : $urandom_range(1, stock))));
	endtask

	// Open a vector of len samples and push count of them, optionally with pops between
	task automatic send_vector(int len, int count, logic [smf_pkg::TIME_W-1:0] stamp,
			bit mix_pops);
		int k;
		send_item(push_item($urandom, 1'b1, smf_pkg::LEN_W'(len), stamp));
		for (k = 1; k < count; k++) begin
			if (mix_pops && $urandom_range(19) == 0)
				send_pop_within_stock();
			send_item(follow_on($urandom));
		end
	endtask

	task automatic test_push_paths();
		send_item(follow_on($urandom));                    // no open vector: drop
		send_item(pop_item(7'd1));                         // empty ring: refuse
		send_item(push_item($urandom, 1'b1, '0, rand_stamp()));  // zero length: refuse
		send_item(follow_on($urandom));
		send_item(push_item('0, 1'b1, 10'd3, '1));
		send_item(follow_on('1));
		send_item(follow_on($urandom));
		send_item(follow_on($urandom));                    // vector complete: drop
		// too long for the space left, so the whole vector goes
		send_item(push_item($urandom, 1'b1, '1, rand_stamp()));
		send_item(follow_on($urandom));
		send_item(follow_on($urandom));
		// abandon a vector part way by opening the next one
		send_item(push_item($urandom, 1'b1, 10'd2, '0));
		send_item(push_item($urandom, 1'b1, 10'd1, rand_stamp()));
	endtask

	task automatic test_pop_paths();
		send_item(pop_item(7'd0));
		send_item(pop_item(7'd127));
		send_item(pop_item(7'd65));
		send_item(pop_item(7'd6));
		send_item(pop_item(7'd5));                         // crosses three marks
		send_item(push_item($urandom, 1'b1, '1, rand_stamp()));  // fits an empty ring
		send_item(follow_on($urandom));
		send_item(follow_on($urandom));
		send_item(push_item($urandom, 1'b1, 10'd1, rand_stamp()));
		send_item(pop_item(7'd4));
	endtask

	task automatic test_stamp_queue_full();
		int k;
		wait_for_drain();
		for (k = 0; k < smf_pkg::TIME_DEPTH; k++)
			send_item(push_item($urandom, 1'b1, 10'd1, rand_stamp()));
		send_item(push_item($urandom, 1'b1, 10'd1, rand_stamp()));  // no stamp room
		send_vector(2, 2, rand_stamp(), 1'b0);
		wait_for_drain();
		send_item(pop_item(smf_pkg::CNT_W'(smf_pkg::MAX_POP)));
	endtask

	task automatic test_random_traffic(int budget, int sender_pct, int receiver_pct);
		int start;
		int pick;
		int len;
		int count;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		start = items_sent;
		while (items_sent - start < budget) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(17, 1023) : $urandom_range(1, 16);
				count = len;
				// cut some vectors short; long ones always
				if (len > 16)
					count = $urandom_range(1, 6);
				else if ($urandom_range(6) == 0)
					count = $urandom_range(1, len);
				send_vector(len, count, rand_stamp(), 1'b1);
			end else if (pick < 85) begin
				send_pop_within_stock();
			end else if (pick < 88) begin
				wait_for_drain();
			end else begin
				case ($urandom_range(3))
					0: send_item(follow_on($urandom));
					1: send_item(pop_item(smf_pkg::CNT_W'($urandom_range(65, 127))));
					2: send_item(pop_item($urandom_range(1) ? 7'd0 : 7'($urandom_range(1, 64))));
					default: send_item(push_item($urandom, 1'b1, '0, rand_stamp()));
				endcase
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		mismatches    = 0;
		items_sent    = 0;
		send_idle_pct = 26;
		recv_idle_pct = 60;
		wr_ptr        = '0;
		rd_ptr        = '0;
		stamp_wr      = '0;
		stamp_rd      = '0;
		stamp_count   = 0;
		discarding    = 1'b0;
		samples_due   = 0;
		vector_start  = '0;
		since_mark    = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_push_paths();
		test_pop_paths();
		test_stamp_queue_full();
		test_random_traffic(47, 26, 60);
		test_random_traffic(46, 60, 26);
		test_random_traffic(46, 0, 0);
		wait_for_drain();
		// allow any stray late result to show up
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== marked_sample_fifo_with_timestamps.f =====
rtl/core/smf_pkg.sv
rtl/core/marked_sample_fifo_with_timestamps.sv
verif/testbench.sv
